// ===== rtl/swe_pkg.sv =====
// ----------------------------------------------------------------------------
// swe_pkg
// Shared types and constants for the sliding window extremum block.
// ----------------------------------------------------------------------------
package swe_pkg;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned WL_W       = 7;

  localparam logic REG_WINDOW_LENGTH = 1'b0;
  localparam logic REG_MODE          = 1'b1;

  localparam logic MODE_MIN = 1'b0;
  localparam logic MODE_MAX = 1'b1;

  localparam logic [WL_W-1:0] WL_RESET   = 7'd1;
  localparam logic            MODE_RESET = MODE_MAX;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } swe_state_t;

endpackage

// ===== rtl/swe_cell.sv =====
// ----------------------------------------------------------------------------
// swe_cell
// One history cell: holds a sample, shifts it onward, and folds it into the
// passing scan token while the token still has samples left to cover.
// ----------------------------------------------------------------------------
module swe_cell
  import swe_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = 32,
  parameter int unsigned LEFT_W       = 7
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           shift_en,
  input  logic                           mode,
  input  logic signed [SAMPLE_WIDTH-1:0] shift_in,
  output logic signed [SAMPLE_WIDTH-1:0] shift_out,
  input  logic                           tok_valid_in,
  input  logic [LEFT_W-1:0]              tok_left_in,
  input  logic signed [SAMPLE_WIDTH-1:0] tok_best_in,
  output logic                           tok_valid_out,
  output logic [LEFT_W-1:0]              tok_left_out,
  output logic signed [SAMPLE_WIDTH-1:0] tok_best_out
);

  logic signed [SAMPLE_WIDTH-1:0] val_r;
  logic                           tok_valid_r;
  logic [LEFT_W-1:0]              tok_left_r, tok_left_nxt;
  logic signed [SAMPLE_WIDTH-1:0] tok_best_r, tok_best_nxt;
  logic                           better;
  logic                           take;

  always_comb begin
    better = (mode == MODE_MAX) ? (val_r > tok_best_in) : (val_r < tok_best_in);
    take   = (tok_left_in != '0);
    tok_best_nxt = (take && better) ? val_r : tok_best_in;
    tok_left_nxt = take ? (tok_left_in - LEFT_W'(1)) : tok_left_in;
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      val_r <= shift_in;
    end
    tok_left_r <= tok_left_nxt;
    tok_best_r <= tok_best_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_valid_r <= 1'b0;
    end else begin
      tok_valid_r <= tok_valid_in;
    end
  end

  assign shift_out     = val_r;
  assign tok_valid_out = tok_valid_r;
  assign tok_left_out  = tok_left_r;
  assign tok_best_out  = tok_best_r;

endmodule

// ===== rtl/sliding_window_extremum_core.sv =====
// ----------------------------------------------------------------------------
// sliding_window_extremum_core
// Running minimum or maximum of signed samples over a programmable window.
// ----------------------------------------------------------------------------
// The history is a chain of WINDOW_MAX cells; an accepted sample shifts in
// at the head and a scan token then walks the whole chain, one cell per
// cycle, picking up the min or max of the newest window_length samples (or
// all samples since reset while fewer have arrived). The finished token's
// result is registered at the output, and the next request is taken only
// once that has happened, so the token's walk down the chain sets how
// often requests can be taken. A finished result that finds the previous
// one still waiting at the output parks in a hold register, and input
// stalls until the output frees. window_length 0 acts as 1 and values
// above WINDOW_MAX act as WINDOW_MAX. mode 1 selects the maximum, mode 0
// the minimum. Registers: window_length at 0x0, mode at 0x4; write only
// while no request is in flight.
module sliding_window_extremum_core
  import swe_pkg::*;
#(
  parameter int unsigned WINDOW_MAX   = 64,
  parameter int unsigned SAMPLE_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] out_extremum,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]          cfg_paddr,
  input  logic [CFG_DATA_W-1:0]          cfg_pwdata,
  output logic [CFG_DATA_W-1:0]          cfg_prdata,
  output logic                           cfg_pready
);

  localparam int unsigned LEFT_W = $clog2(WINDOW_MAX + 1);
  localparam int unsigned CW     = (LEFT_W > WL_W) ? LEFT_W : WL_W;

  swe_state_t state_r, state_nxt;

  logic [WL_W-1:0]   wl_r;
  logic              mode_r;
  logic              cfg_wr;
  logic [LEFT_W-1:0] seen_r, seen_nxt;
  logic [CW-1:0]     span_c;
  logic [LEFT_W-1:0] span;
  logic              in_acc;

  logic                           tok0_valid_r;
  logic [LEFT_W-1:0]              tok0_left_r;
  logic signed [SAMPLE_WIDTH-1:0] tok0_best_r;

  logic signed [SAMPLE_WIDTH-1:0] hold_r;
  logic                           out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] out_extremum_r;

  logic                           out_free;
  logic                           load_out;
  logic                           load_from_hold;
  logic                           load_hold;

  logic signed [SAMPLE_WIDTH-1:0] sh   [WINDOW_MAX+1];
  logic                           tv   [WINDOW_MAX+1];
  logic [LEFT_W-1:0]              tl   [WINDOW_MAX+1];
  logic signed [SAMPLE_WIDTH-1:0] tb   [WINDOW_MAX+1];

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r   <= WL_RESET;
      mode_r <= MODE_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_WINDOW_LENGTH: wl_r   <= cfg_pwdata[WL_W-1:0];
        REG_MODE:          mode_r <= cfg_pwdata[0];
        default:           ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_WINDOW_LENGTH: cfg_prdata = CFG_DATA_W'(wl_r);
      REG_MODE:          cfg_prdata = CFG_DATA_W'(mode_r);
      default:           cfg_prdata = '0;
    endcase
  end

  // span of the scan for the incoming sample
  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid & in_ready;
  assign seen_nxt = (seen_r == LEFT_W'(WINDOW_MAX)) ? seen_r : (seen_r + LEFT_W'(1));

  always_comb begin
    span_c = CW'(wl_r);
    if (span_c == '0) begin
      span_c = CW'(1);
    end
    if (span_c > CW'(WINDOW_MAX)) begin
      span_c = CW'(WINDOW_MAX);
    end
    if (span_c > CW'(seen_nxt)) begin
      span_c = CW'(seen_nxt);
    end
    span = span_c[LEFT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r       <= '0;
      tok0_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        seen_r <= seen_nxt;
      end
      tok0_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      tok0_left_r <= span;
      tok0_best_r <= in_sample;
    end
  end

  // cell chain
  assign sh[0] = in_sample;
  assign tv[0] = tok0_valid_r;
  assign tl[0] = tok0_left_r;
  assign tb[0] = tok0_best_r;

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    swe_cell #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .LEFT_W       (LEFT_W)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .shift_en      (in_acc),
      .mode          (mode_r),
      .shift_in      (sh[i]),
      .shift_out     (sh[i+1]),
      .tok_valid_in  (tv[i]),
      .tok_left_in   (tl[i]),
      .tok_best_in   (tb[i]),
      .tok_valid_out (tv[i+1]),
      .tok_left_out  (tl[i+1]),
      .tok_best_out  (tb[i+1])
    );
  end

  // control
  assign out_free = ~out_valid_r | out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_SCAN;
      ST_SCAN: if (tv[WINDOW_MAX]) state_nxt = out_free ? ST_IDLE : ST_HOLD;
      ST_HOLD: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    load_out       = 1'b0;
    load_from_hold = 1'b0;
    load_hold      = 1'b0;
    unique case (state_r)
      ST_IDLE: ;
      ST_SCAN: begin
        load_out  = tv[WINDOW_MAX] & out_free;
        load_hold = tv[WINDOW_MAX] & ~out_free;
      end
      ST_HOLD: begin
        load_out       = out_free;
        load_from_hold = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_hold) begin
      hold_r <= tb[WINDOW_MAX];
    end
    if (load_out) begin
      out_extremum_r <= load_from_hold ? hold_r : tb[WINDOW_MAX];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_extremum = out_extremum_r;

endmodule

// ===== rtl/swe_checker.sv =====
// ----------------------------------------------------------------------------
// swe_checker
// Port-level checks for the sliding window extremum block.
// ----------------------------------------------------------------------------
module swe_checker
  import swe_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = 32
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic signed [SAMPLE_WIDTH-1:0] out_extremum,
  input logic                           cfg_pready
);

  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after a request");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_extremum)))
    else $error("stalled result dropped or changed");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_pready_high: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("pready low");

endmodule

bind sliding_window_extremum_core swe_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_swe_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_extremum (out_extremum),
  .cfg_pready   (cfg_pready)
);

// ===== test/sliding_window_extremum_core_tb.sv =====
// ----------------------------------------------------------------------------
// sliding_window_extremum_core_tb
// Streams signed samples through the window extremum core under several
// window and mode settings. Random idles sit on both channels, with long
// output stalls and a full-rate stretch. Each result is checked against a
// running window minimum or maximum kept in the bench. Register writes are
// read back over the same port.
// ----------------------------------------------------------------------------
module sliding_window_extremum_core_tb;
  import swe_pkg::*;

  localparam int unsigned WINDOW_MAX    = 64;
  localparam int unsigned SAMPLE_WIDTH  = 32;
  localparam int unsigned SETTLE_CYCLES = WINDOW_MAX + 8;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned IDLE_PERCENT  = 11;
  localparam int unsigned SWEEP_PHASES  = 12;
  localparam int unsigned PHASE_ITEMS   = 108;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  sample_t               in_sample   = '0;
  logic                  out_valid;
  logic                  out_ready   = 1'b0;
  sample_t               out_extremum;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  sample_t         history [WINDOW_MAX];
  int unsigned     next_slot     = 0;
  int unsigned     filled_count  = 0;
  logic [WL_W-1:0] window_len    = WL_RESET;
  logic            extremum_mode = MODE_RESET;
  sample_t         pending_extrema [$];
  sample_t         wanted_extremum;
  sample_t         last_sample   = '0;

  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  bit          idle_in_en     = 1'b1;
  bit          idle_out_en    = 1'b1;
  int unsigned hold_requests  = 0;
  int unsigned hold_served    = 0;
  int unsigned hold_left      = 0;

  sliding_window_extremum_core #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_sample   (in_sample),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_extremum(out_extremum),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // store the sample, then scan the newest covered entries
  function automatic sample_t store_and_scan(input sample_t s);
    int unsigned span;
    int unsigned idx;
    int unsigned k;
    sample_t     best;
    history[next_slot] = s;
    idx = next_slot;
    next_slot = (next_slot + 1) % WINDOW_MAX;
    if (filled_count < WINDOW_MAX) filled_count++;
    span = (window_len == 0) ? 1 : window_len;
    if (span > WINDOW_MAX) span = WINDOW_MAX;
    if (span > filled_count) span = filled_count;
    best = s;
    for (k = 1; k < span; k++) begin
      idx = (idx + WINDOW_MAX - 1) % WINDOW_MAX;
      if (extremum_mode == MODE_MAX) begin
        if (history[idx] > best) best = history[idx];
      end else begin
        if (history[idx] < best) best = history[idx];
      end
    end
    return best;
  endfunction

  // mix of full-range values, extremes, ties and ramps so extremes age out
  function automatic sample_t pick_sample();
    sample_t s;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: s = $urandom;
      4: begin
        case ($urandom_range(0, 4))
          0: s = 32'sh8000_0000;
          1: s = 32'sh7fff_ffff;
          2: s = '0;
          3: s = -1;
          default: s = 1;
        endcase
      end
      5: s = $signed($urandom_range(0, 64)) - 32;
      6: s = last_sample;
      7: s = last_sample + $signed($urandom_range(0, 1000));
      8: s = last_sample - $signed($urandom_range(0, 1000));
      default: begin
        s = 32'sd1 <<< $urandom_range(0, SAMPLE_WIDTH - 1);
        if ($urandom_range(0, 1) == 1) s = ~s;
      end
    endcase
    last_sample = s;
    return s;
  endfunction

  task automatic send_sample(input sample_t s);
    int unsigned gap;
    gap = 0;
    while (idle_in_en && $urandom_range(0, 99) < IDLE_PERCENT) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_extrema.push_back(store_and_scan(s));
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) send_sample(pick_sample());
  endtask

  // drop valid, drain every pending result, then let the scan chain empty
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_extrema.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] data);
    logic [CFG_DATA_W-1:0] kept;
    wait_idle();
    if (idx == REG_WINDOW_LENGTH) kept = data & {{(CFG_DATA_W-WL_W){1'b0}}, {WL_W{1'b1}}};
    else kept = data & {{(CFG_DATA_W-1){1'b0}}, 1'b1};
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (idx == REG_WINDOW_LENGTH) window_len = kept[WL_W-1:0];
    else extremum_mode = kept[0];
    // read back
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== kept) begin
      $display("%0t: register %0d readback expected %h actual %h",
               $time, idx, kept, cfg_prdata);
      mismatch_count++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_window(input logic [CFG_DATA_W-1:0] len, input logic mode_sel);
    write_reg(REG_WINDOW_LENGTH, len);
    write_reg(REG_MODE, {{(CFG_DATA_W-1){1'b0}}, mode_sel});
  endtask

  task automatic test_short_history();
    set_window(8, MODE_MIN);
    send_sample(100);
    send_sample(-5);
    send_sample(32'sh7fff_ffff);
    send_sample(-5);
    send_sample(32'sh8000_0000);
    send_sample(32'sh8000_0000);
  endtask

  task automatic test_window_limits();
    set_window(0, MODE_MAX);
    send_sample(32'sh7fff_ffff);
    send_sample(32'sh8000_0000);
    send_sample(0);
    send_sample(-1);
    set_window(127, MODE_MIN);
    send_random(4);
    set_window(65, MODE_MAX);
    send_random(4);
    set_window(1, MODE_MIN);
    send_sample(1);
    send_sample(-1);
  endtask

  task automatic test_window_sweep();
    int unsigned phase;
    logic [CFG_DATA_W-1:0] len;
    logic mode_sel;
    for (phase = 0; phase < SWEEP_PHASES; phase++) begin
      case (phase)
        0: begin len = 1;   mode_sel = MODE_MIN; end
        1: begin len = 64;  mode_sel = MODE_MAX; end
        2: begin len = 2;   mode_sel = MODE_MAX; end
        3: begin len = 63;  mode_sel = MODE_MIN; end
        4: begin len = 0;   mode_sel = MODE_MIN; end
        5: begin len = 127; mode_sel = MODE_MAX; end
        default: begin
          len = ($urandom_range(0, 5) == 0) ? $urandom_range(65, 127) : $urandom_range(1, 64);
          mode_sel = 1'($urandom_range(0, 1));
        end
      endcase
      // junk in the upper bits must be dropped
      if (phase >= 6 && $urandom_range(0, 1) == 1) begin
        write_reg(REG_WINDOW_LENGTH, len | ($urandom & ~32'h7f));
        write_reg(REG_MODE, {31'd0, mode_sel} | ($urandom & ~32'h1));
      end else begin
        set_window(len, mode_sel);
      end
      send_random(PHASE_ITEMS);
    end
  endtask

  task automatic test_output_backpressure();
    set_window(16, MODE_MAX);
    hold_requests++;
    send_random(40);
    wait_idle();
  endtask

  task automatic test_full_rate();
    set_window(32, MODE_MIN);
    idle_in_en  = 1'b0;
    idle_out_en = 1'b0;
    send_random(150);
    wait_idle();
    idle_in_en  = 1'b1;
    idle_out_en = 1'b1;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_extrema.size() == 0) begin
        $display("%0t: extremum expected none actual %h", $time, out_extremum);
        mismatch_count++;
      end else begin
        wanted_extremum = pending_extrema.pop_front();
        if (out_extremum !== wanted_extremum) begin
          $display("%0t: extremum expected %h actual %h",
                   $time, wanted_extremum, out_extremum);
          mismatch_count++;
        end
      end
    end
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(idle_out_en && $urandom_range(0, 99) < IDLE_PERCENT);
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_short_history();
    test_window_limits();
    test_output_backpressure();
    test_full_rate();
    test_window_sweep();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sliding_window_extremum_core.f =====
rtl/swe_pkg.sv
rtl/swe_cell.sv
rtl/sliding_window_extremum_core.sv
rtl/swe_checker.sv
test/sliding_window_extremum_core_tb.sv
